// ===== rtl/core/hpr_pkg.sv =====
// ----------------------------------------------------------------------------
// hpr_pkg
// Shared types, constants and helpers for the held packet reorder buffer.
// ----------------------------------------------------------------------------
package hpr_pkg;

    localparam int HOLD_SLOTS    = 16;
    localparam int SLOT_BITS     = $clog2(HOLD_SLOTS);
    localparam int TAG_BITS      = 16;
    localparam int COUNT_BITS    = 8;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_ONLY_MATCHING = 1'd1;

    // Register reset values
    localparam logic [COUNT_BITS-1:0] THRESHOLD_RESET = 8'd1;

    typedef struct packed {
        logic [TAG_BITS-1:0] packet_tag;
        logic                is_corrupted;
        logic                matches_filter;
    } in_word_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] out_tag;
        logic                was_held;
        logic                hold_overflow;
        logic                last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] release_threshold;
        logic                  count_only_matching;
    } cfg_t;

    // Classified word as it waits between front and back
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                hold;     // corrupted: held in a slot when one is free
        logic                counted;  // passing word that advances held counts
    } job_t;

    // Head of the job queue as seen by the back part
    typedef struct packed {
        logic valid;
        job_t job;
    } queue_head_t;

    // Index of the lowest set bit; zero when none is set
    function automatic logic [SLOT_BITS-1:0] lowest_set(input logic [HOLD_SLOTS-1:0] vec);
        logic [SLOT_BITS-1:0] idx;
        idx = '0;
        for (int i = HOLD_SLOTS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = SLOT_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/core/hpr_front.sv =====
// ----------------------------------------------------------------------------
// hpr_front
// Accepts input words, classifies them and queues them for the back part.
// ----------------------------------------------------------------------------
module hpr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  hpr_pkg::in_word_t    item,
    input  hpr_pkg::cfg_t        cfg,
    input  logic                 pop,
    output logic                 busy,
    output hpr_pkg::queue_head_t head
);
    import hpr_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    job_t       queue_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       do_pop;
    job_t       job_in;

    // Classify the incoming word
    always_comb
    begin
        job_in.tag     = item.packet_tag;
        job_in.hold    = item.is_corrupted;
        job_in.counted = !cfg.count_only_matching || item.matches_filter;
    end

    assign busy   = (fill_reg == 2'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (fill_reg != 2'd0);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the classified word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign head.valid = (fill_reg != 2'd0);
    assign head.job   = queue_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/hpr_back.sv =====
// ----------------------------------------------------------------------------
// hpr_back
// Executes queued words against the hold store and drives result words.
// ----------------------------------------------------------------------------
module hpr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpr_pkg::queue_head_t head,
    input  hpr_pkg::cfg_t        cfg,
    output logic                 pop,
    output logic                 result_valid,
    output hpr_pkg::out_word_t   result
);
    import hpr_pkg::*;

    localparam logic ST_EXEC    = 1'b0;
    localparam logic ST_RELEASE = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [HOLD_SLOTS-1:0] valid_reg;
    logic [HOLD_SLOTS-1:0] valid_next;
    logic [COUNT_BITS-1:0] count_reg [HOLD_SLOTS];
    logic [COUNT_BITS-1:0] count_next [HOLD_SLOTS];
    logic [TAG_BITS-1:0]   tag_reg [HOLD_SLOTS];
    logic [HOLD_SLOTS-1:0] pend_reg;
    logic [HOLD_SLOTS-1:0] pend_next;
    out_word_t             result_reg;
    out_word_t             result_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;

    logic [HOLD_SLOTS-1:0] free_slots;
    logic [SLOT_BITS-1:0]  free_idx;
    logic [HOLD_SLOTS-1:0] bumped_valid;
    logic [COUNT_BITS-1:0] bumped [HOLD_SLOTS];
    logic [HOLD_SLOTS-1:0] due;
    logic [SLOT_BITS-1:0]  rel_idx;
    logic [HOLD_SLOTS-1:0] rel_onehot;
    logic                  tag_we;

    assign free_slots = ~valid_reg;
    assign free_idx   = lowest_set(free_slots);
    assign rel_idx    = lowest_set(pend_reg);
    assign rel_onehot = HOLD_SLOTS'(1) << rel_idx;

    // Bump held counts and flag entries that reach the threshold
    always_comb
    begin
        for (int i = 0; i < HOLD_SLOTS; i++)
        begin
            bumped_valid[i] = valid_reg[i] && head.job.counted && (count_reg[i] != COUNT_MAX);
            bumped[i]       = bumped_valid[i] ? count_reg[i] + COUNT_BITS'(1) : count_reg[i];
            due[i]          = valid_reg[i] && (bumped[i] >= cfg.release_threshold);
        end
    end

    // Sequence execution and release
    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        count_next        = count_reg;
        pend_next         = pend_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        pop               = 1'b0;
        tag_we            = 1'b0;

        unique case (state_reg)
            ST_EXEC:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.job.hold)
                    begin
                        if (|free_slots)
                        begin
                            // Park the word in the lowest free slot
                            tag_we               = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            count_next[free_idx] = '0;
                        end
                        else
                        begin
                            // Store full: pass it through flagged
                            result_valid_next         = 1'b1;
                            result_next.out_tag       = head.job.tag;
                            result_next.was_held      = 1'b0;
                            result_next.hold_overflow = 1'b1;
                            result_next.last_of_run   = 1'b1;
                        end
                    end
                    else
                    begin
                        // Forward, then queue up due entries
                        result_valid_next         = 1'b1;
                        result_next.out_tag       = head.job.tag;
                        result_next.was_held      = 1'b0;
                        result_next.hold_overflow = 1'b0;
                        result_next.last_of_run   = (due == '0);
                        count_next                = bumped;
                        pend_next                 = due;
                        if (due != '0)
                        begin
                            state_next = ST_RELEASE;
                        end
                    end
                end
            end
            ST_RELEASE:
            begin
                // Emit one due entry per cycle in slot order
                result_valid_next         = 1'b1;
                result_next.out_tag       = tag_reg[rel_idx];
                result_next.was_held      = 1'b1;
                result_next.hold_overflow = 1'b0;
                result_next.last_of_run   = ((pend_reg & ~rel_onehot) == '0);
                pend_next                 = pend_reg & ~rel_onehot;
                valid_next[rel_idx]       = 1'b0;
                count_next[rel_idx]       = '0;
                if ((pend_reg & ~rel_onehot) == '0)
                begin
                    state_next = ST_EXEC;
                end
            end
            default:
            begin
                state_next = ST_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_EXEC;
            valid_reg        <= '0;
            pend_reg         <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < HOLD_SLOTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            count_reg        <= count_next;
        end
    end

    // Hold tags and the result word
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (tag_we)
        begin
            tag_reg[free_idx] <= head.job.tag;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/held_packet_reorder_buffer_top.sv =====
// ----------------------------------------------------------------------------
// held_packet_reorder_buffer_top
// Holds corrupted packets and releases them after a number of passing packets.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; a two-entry queue sits
// between the input and the execution logic, so busy rises only when both
// entries wait. Execution pauses for each held packet that it releases, since
// released words leave one per cycle through the single result register.
// Results appear on result with result_valid high for exactly one cycle and
// cannot be held off; the final result caused by an input carries last_of_run.
// A held corrupted packet gives no result. An accepted word passes through
// the queue and the result register before its result reaches the ports.
// ----------------------------------------------------------------------------
module held_packet_reorder_buffer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  hpr_pkg::in_word_t                   item,
    output logic                                result_valid,
    output hpr_pkg::out_word_t                  result,
    input  logic                                cfg_we,
    input  logic [hpr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [hpr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import hpr_pkg::*;

    cfg_t        cfg_reg;
    queue_head_t head;
    logic        pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_threshold   <= THRESHOLD_RESET;
            cfg_reg.count_only_matching <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RELEASE_THRESHOLD:
                begin
                    cfg_reg.release_threshold <= cfg_data[COUNT_BITS-1:0];
                end
                REG_COUNT_ONLY_MATCHING:
                begin
                    cfg_reg.count_only_matching <= cfg_data[0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    hpr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .cfg   (cfg_reg),
        .pop   (pop),
        .busy  (busy),
        .head  (head)
    );

    hpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .cfg          (cfg_reg),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
